### rtl/bip_pkg.sv
// package for the boot information tag parser
// holds tag codes, walk limits, state and event enums and the control structs
// no dependencies
package bip_pkg;

   localparam int unsigned MAX_BLOCK_BYTES = 65536;
   localparam int unsigned WALK_LIMIT = (MAX_BLOCK_BYTES < 65536) ? MAX_BLOCK_BYTES : 65536;
   localparam logic [33:0] WALK_LIMIT_W = 34'(WALK_LIMIT);

   localparam int unsigned MAP_ENTRY_STRIDE = 24;
   localparam int unsigned DIV_STEPS = 32;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [31:0] TAG_END = 32'd0;
   localparam logic [31:0] TAG_CMDLINE = 32'd1;
   localparam logic [31:0] TAG_LOADER = 32'd2;
   localparam logic [31:0] TAG_MMAP = 32'd6;
   localparam logic [31:0] TAG_ELF = 32'd9;
   localparam logic [31:0] MMAP_AVAILABLE = 32'd1;

   localparam logic [31:0] MIN_TAG_BYTES = 32'd8;
   localparam logic [31:0] MIN_MMAP_BYTES = 32'd16;
   localparam logic [16:0] HDR_BYTES = 17'd8;
   localparam logic [16:0] SIZE_WORD_OFS = 17'd4;
   localparam logic [16:0] BODY_WORD_OFS = 17'd8;
   localparam logic [15:0] STRING_OFS = 16'd8;
   localparam logic [15:0] ELF_ARRAY_OFS = 16'd20;
   localparam logic [15:0] MMAP_ENTRY_OFS = 16'd16;
   localparam logic [16:0] ENTRY_TYPE_OFS = 17'd16;
   localparam logic [17:0] ENTRY_TYPE_END = 18'd20;

   typedef enum logic [2:0] {
      KIND_OTHER  = 3'd0,
      KIND_CMD    = 3'd1,
      KIND_LOADER = 3'd2,
      KIND_MAP    = 3'd3,
      KIND_ELF    = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_BAD_SIZE = 2'd1,
      STS_BAD_MAP  = 2'd2,
      STS_OVERRUN  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_END      = 3'd1,
      EV_BAD_SIZE = 3'd2,
      EV_BAD_MAP  = 3'd3,
      EV_OVERRUN  = 3'd4,
      EV_DIVIDE   = 3'd5
   } evt_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_WALK   = 2'd1,
      ST_DIVIDE = 2'd2,
      ST_FINISH = 2'd3
   } state_type;

   typedef struct packed {
      logic       restart;
      logic       step;
      logic       div_run;
      logic       div_finish;
      logic       emit;
      status_type code;
   } cmd_type;

   typedef struct packed {
      evt_type evt;
      logic    div_last;
      logic    div_overrun;
      logic    out_full;
   } sts_type;

   typedef struct packed {
      logic [15:0] cmdline_offset;
      logic [15:0] loader_name_offset;
      logic [15:0] memmap_offset;
      logic [15:0] memmap_count;
      logic [15:0] elf_offset;
      logic [31:0] elf_count;
      logic [1:0]  status;
   } rsp_type;

endpackage

### rtl/bip_req_if.sv
// word channel into the boot information tag parser
// valid/ready handshake with the block word and the first-word flag
interface bip_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] word;
   logic        first;

   modport source (output valid, output word, output first, input ready);
   modport sink (input valid, input word, input first, output ready);
endinterface

### rtl/bip_rsp_if.sv
// summary channel out of the boot information tag parser
// valid/ready handshake with the offsets, counts and status of one walk
interface bip_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] cmdline_offset;
   logic [15:0] loader_name_offset;
   logic [15:0] memmap_offset;
   logic [15:0] memmap_count;
   logic [15:0] elf_offset;
   logic [31:0] elf_count;
   logic [1:0]  status;

   modport source (output valid, output cmdline_offset, output loader_name_offset,
                   output memmap_offset, output memmap_count, output elf_offset,
                   output elf_count, output status, input ready);
   modport sink (input valid, input cmdline_offset, input loader_name_offset,
                 input memmap_offset, input memmap_count, input elf_offset,
                 input elf_count, input status, output ready);
endinterface

### rtl/bip_datapath.sv
// datapath of the tag parser: position tracking, tag fields, entry divider,
// and the two-entry summary buffer; uses bip_pkg
module bip_datapath import bip_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [31:0] req_word,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   logic [16:0]          byte_pos_ff, byte_pos_in;
   logic [16:0]          next_tag_pos_ff, next_tag_pos_in;
   logic [15:0]          tag_start_ff, tag_start_in;
   kind_type             tag_kind_ff, tag_kind_in;
   logic [31:0]          divisor_ff, divisor_in;
   logic [31:0]          left_ff, left_in;
   logic                 searching_ff, searching_in;
   logic [63:0]          work_ff, work_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [15:0]          cmd_off_ff, cmd_off_in;
   logic [15:0]          ldr_off_ff, ldr_off_in;
   logic [15:0]          map_off_ff, map_off_in;
   logic [15:0]          elf_off_ff, elf_off_in;
   logic [31:0]          elf_count_ff, elf_count_in;

   logic    slot0_v_ff, slot0_v_in, slot1_v_ff, slot1_v_in;
   rsp_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   rsp_type summary;
   logic    pop;

   logic        p_ge8, at_hdr, at_size, at_body, at_entry;
   logic [32:0] padded;
   logic [33:0] nt;
   logic        size_overrun;
   logic [16:0] next_off;
   logic        entry_overrun;
   logic [31:0] left_dec;
   logic [32:0] trial;
   logic [15:0] first_entry;
   logic        quot_nonzero;

   // word classification
   always_comb begin
      p_ge8 = |byte_pos_ff[16:3];
      at_hdr = byte_pos_ff == next_tag_pos_ff;
      at_size = byte_pos_ff == ({1'b0, tag_start_ff} + SIZE_WORD_OFS);
      at_body = byte_pos_ff == ({1'b0, tag_start_ff} + BODY_WORD_OFS);
      at_entry = (tag_kind_ff == KIND_MAP) && searching_ff &&
                 (byte_pos_ff == ({1'b0, map_off_ff} + ENTRY_TYPE_OFS));
      padded = ({1'b0, req_word} + 33'd7) & ~33'd7;
      nt = {1'b0, padded} + {18'd0, tag_start_ff};
      size_overrun = (nt + 34'(HDR_BYTES)) > WALK_LIMIT_W;
      next_off = {1'b0, map_off_ff} + 17'(MAP_ENTRY_STRIDE);
      entry_overrun = next_off[16] ||
                      (({1'b0, next_off} + ENTRY_TYPE_END) > {1'b0, next_tag_pos_ff});
      left_dec = left_ff - 32'd1;
      first_entry = tag_start_ff + MMAP_ENTRY_OFS;
      quot_nonzero = |work_ff[31:0];

      sts.evt = EV_NONE;
      if (p_ge8) begin
         if (at_hdr) begin
            if (req_word == TAG_END) begin
               sts.evt = EV_END;
            end
         end else if (at_size) begin
            if (req_word < MIN_TAG_BYTES) begin
               sts.evt = EV_BAD_SIZE;
            end else if (tag_kind_ff == KIND_MAP && req_word < MIN_MMAP_BYTES) begin
               sts.evt = EV_BAD_MAP;
            end else if (size_overrun) begin
               sts.evt = EV_OVERRUN;
            end
         end else if (at_body) begin
            if (tag_kind_ff == KIND_MAP) begin
               sts.evt = (req_word == 32'd0) ? EV_BAD_MAP : EV_DIVIDE;
            end
         end else if (at_entry) begin
            if (req_word != MMAP_AVAILABLE && left_dec != 32'd0 && entry_overrun) begin
               sts.evt = EV_OVERRUN;
            end
         end
      end
      sts.div_last = div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);
      sts.div_overrun = quot_nonzero &&
                        (({2'b0, first_entry} + ENTRY_TYPE_END) > {1'b0, next_tag_pos_ff});
      sts.out_full = slot1_v_ff;
   end

   // restoring divide step, one quotient bit per cycle
   assign trial = {work_ff[63:32], work_ff[31]} - {1'b0, divisor_ff};

   always_comb begin
      byte_pos_in = byte_pos_ff;
      next_tag_pos_in = next_tag_pos_ff;
      tag_start_in = tag_start_ff;
      tag_kind_in = tag_kind_ff;
      divisor_in = divisor_ff;
      left_in = left_ff;
      searching_in = searching_ff;
      work_in = work_ff;
      div_cnt_in = div_cnt_ff;
      cmd_off_in = cmd_off_ff;
      ldr_off_in = ldr_off_ff;
      map_off_in = map_off_ff;
      elf_off_in = elf_off_ff;
      elf_count_in = elf_count_ff;

      if (cmd.restart) begin
         byte_pos_in = SIZE_WORD_OFS;
         next_tag_pos_in = HDR_BYTES;
         tag_start_in = '0;
         tag_kind_in = KIND_OTHER;
         left_in = '0;
         searching_in = 1'b0;
         work_in = '0;
         cmd_off_in = '0;
         ldr_off_in = '0;
         map_off_in = '0;
         elf_off_in = '0;
         elf_count_in = '0;
      end else if (cmd.step) begin
         byte_pos_in = byte_pos_ff + SIZE_WORD_OFS;
         if (p_ge8) begin
            if (at_hdr) begin
               tag_start_in = byte_pos_ff[15:0];
               searching_in = 1'b0;
               case (req_word)
                  TAG_END: begin
                  end
                  TAG_CMDLINE: begin
                     tag_kind_in = KIND_CMD;
                     cmd_off_in = byte_pos_ff[15:0] + STRING_OFS;
                  end
                  TAG_LOADER: begin
                     tag_kind_in = KIND_LOADER;
                     ldr_off_in = byte_pos_ff[15:0] + STRING_OFS;
                  end
                  TAG_MMAP: begin
                     tag_kind_in = KIND_MAP;
                     map_off_in = '0;
                     left_in = '0;
                  end
                  TAG_ELF: begin
                     tag_kind_in = KIND_ELF;
                     elf_off_in = byte_pos_ff[15:0] + ELF_ARRAY_OFS;
                     elf_count_in = '0;
                  end
                  default: begin
                     tag_kind_in = KIND_OTHER;
                  end
               endcase
            end else if (at_size) begin
               if (sts.evt == EV_NONE) begin
                  next_tag_pos_in = nt[16:0];
                  if (tag_kind_ff == KIND_MAP) begin
                     work_in = {32'd0, req_word - MIN_MMAP_BYTES};
                  end
               end
            end else if (at_body) begin
               if (tag_kind_ff == KIND_ELF) begin
                  elf_count_in = req_word;
               end else if (sts.evt == EV_DIVIDE) begin
                  divisor_in = req_word;
                  div_cnt_in = '0;
               end
            end else if (at_entry) begin
               if (req_word == MMAP_AVAILABLE) begin
                  searching_in = 1'b0;
               end else begin
                  left_in = left_dec;
                  if (left_dec == 32'd0) begin
                     map_off_in = '0;
                     searching_in = 1'b0;
                  end else begin
                     map_off_in = next_off[15:0];
                  end
               end
            end
         end
      end else if (cmd.div_run) begin
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         if (!trial[32]) begin
            work_in = {trial[31:0], work_ff[30:0], 1'b1};
         end else begin
            work_in = {work_ff[62:31], work_ff[30:0], 1'b0};
         end
      end else if (cmd.div_finish) begin
         left_in = work_ff[31:0];
         if (quot_nonzero) begin
            map_off_in = first_entry;
            searching_in = 1'b1;
         end
      end
      if (cmd.emit) begin
         searching_in = 1'b0;
      end
   end

   // summary taken from the updated fields
   always_comb begin
      summary.cmdline_offset = cmd_off_in;
      summary.loader_name_offset = ldr_off_in;
      summary.memmap_offset = map_off_in;
      summary.memmap_count = (|left_in[31:16]) ? 16'hFFFF : left_in[15:0];
      summary.elf_offset = elf_off_in;
      summary.elf_count = elf_count_in;
      summary.status = cmd.code;
   end

   // two-entry output buffer
   assign pop = slot0_v_ff && rsp_ready;

   always_comb begin
      slot0_v_in = slot0_v_ff;
      slot1_v_in = slot1_v_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (slot1_v_ff) begin
         if (pop) begin
            slot0_in = slot1_ff;
            slot1_v_in = 1'b0;
         end
      end else if (cmd.emit) begin
         if (!slot0_v_ff || pop) begin
            slot0_in = summary;
            slot0_v_in = 1'b1;
         end else begin
            slot1_in = summary;
            slot1_v_in = 1'b1;
         end
      end else if (pop) begin
         slot0_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot0_v_ff <= 1'b0;
         slot1_v_ff <= 1'b0;
      end else begin
         slot0_v_ff <= slot0_v_in;
         slot1_v_ff <= slot1_v_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      byte_pos_ff <= byte_pos_in;
      next_tag_pos_ff <= next_tag_pos_in;
      tag_start_ff <= tag_start_in;
      tag_kind_ff <= tag_kind_in;
      divisor_ff <= divisor_in;
      left_ff <= left_in;
      searching_ff <= searching_in;
      work_ff <= work_in;
      div_cnt_ff <= div_cnt_in;
      cmd_off_ff <= cmd_off_in;
      ldr_off_ff <= ldr_off_in;
      map_off_ff <= map_off_in;
      elf_off_ff <= elf_off_in;
      elf_count_ff <= elf_count_in;
   end

   assign rsp_valid = slot0_v_ff;
   assign rsp_data = slot0_ff;

endmodule

### rtl/bip_ctrl.sv
// controller of the tag parser: walk state, word acceptance, divide sequencing
// and summary emission; uses bip_pkg
module bip_ctrl import bip_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_first,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.code = STS_OK;
      req_ready = 1'b0;
      accept = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !sts.out_full;
            accept = req_valid && !sts.out_full;
            if (accept && req_first) begin
               cmd.restart = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            req_ready = !sts.out_full;
            accept = req_valid && !sts.out_full;
            if (accept) begin
               if (req_first) begin
                  cmd.restart = 1'b1;
               end else begin
                  cmd.step = 1'b1;
                  case (sts.evt)
                     EV_END: begin
                        cmd.emit = 1'b1;
                        cmd.code = STS_OK;
                        state_in = ST_IDLE;
                     end
                     EV_BAD_SIZE: begin
                        cmd.emit = 1'b1;
                        cmd.code = STS_BAD_SIZE;
                        state_in = ST_IDLE;
                     end
                     EV_BAD_MAP: begin
                        cmd.emit = 1'b1;
                        cmd.code = STS_BAD_MAP;
                        state_in = ST_IDLE;
                     end
                     EV_OVERRUN: begin
                        cmd.emit = 1'b1;
                        cmd.code = STS_OVERRUN;
                        state_in = ST_IDLE;
                     end
                     EV_DIVIDE: begin
                        state_in = ST_DIVIDE;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_run = 1'b1;
            if (sts.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.div_finish = 1'b1;
            if (sts.div_overrun) begin
               cmd.emit = 1'b1;
               cmd.code = STS_OVERRUN;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_WALK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/boot_info_tag_parser.sv
// boot information tag parser, top level
// joins bip_ctrl and bip_datapath; uses bip_pkg, bip_req_if, bip_rsp_if
//
// req_bus carries the block as little-endian 32-bit words, one transaction
// per word; first marks word 0 and restarts the walk. Words with first low
// while no walk runs are taken and dropped. The two header words are skipped,
// then tags are walked until a type-0 tag or an error, which produces one
// summary transaction on rsp_bus.
// Throughput is one word per cycle. The entry-size word of a memory map tag
// with a nonzero entry size holds req_bus.ready low for the 32 steps
// of the one-bit-per-cycle restoring divider for the entry count and a
// final step that places the first entry.
// The summary is registered into the output buffer as the terminating or
// failing word is taken (at the finish step after the divide for a map overrun).
// Results go through a two-entry output buffer, so words keep flowing while
// one summary waits; with both entries held, req_bus.ready drops.
// Reset is synchronous; afterward the block waits for a first word.
module boot_info_tag_parser import bip_pkg::*; (
   input logic        clock,
   input logic        reset,
   bip_req_if.sink    req_bus,
   bip_rsp_if.source  rsp_bus
);

   cmd_type cmd;
   sts_type sts;
   rsp_type rsp_data;

   bip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_first (req_bus.first),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bip_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_word  (req_bus.word),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_bus.cmdline_offset = rsp_data.cmdline_offset;
   assign rsp_bus.loader_name_offset = rsp_data.loader_name_offset;
   assign rsp_bus.memmap_offset = rsp_data.memmap_offset;
   assign rsp_bus.memmap_count = rsp_data.memmap_count;
   assign rsp_bus.elf_offset = rsp_data.elf_offset;
   assign rsp_bus.elf_count = rsp_data.elf_count;
   assign rsp_bus.status = rsp_data.status;

   // no summary into a full buffer
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !sts.out_full)
      else $error("summary emitted with output buffer full");

   // input held off while dividing
   a_stall_divide: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_run || cmd.div_finish) |-> !req_bus.ready)
      else $error("word taken during entry count divide");

   // last divide step is followed by the finish cycle
   a_divide_finish: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_run && sts.div_last) |=> cmd.div_finish)
      else $error("divide finish missing");

   // restart and word processing are exclusive
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.restart && (cmd.step || cmd.div_run || cmd.div_finish)))
      else $error("conflicting datapath commands");

endmodule
